@@ src/rtu_frm_pkg.sv @@
package rtu_frm_pkg;

   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam logic [15:0] CRC_POLY     = 16'hA001;
   localparam logic [7:0]  FC_READ      = 8'h03;
   localparam logic [7:0]  FC_WRITE     = 8'h06;
   localparam logic [15:0] MAX_READ_QTY = 16'd125;

   localparam logic ACTION_READ  = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   // Positions of the bytes within one frame, in transmission order.
   localparam logic [2:0] BYTE_SLAVE   = 3'd0;
   localparam logic [2:0] BYTE_FCODE   = 3'd1;
   localparam logic [2:0] BYTE_ADDR_HI = 3'd2;
   localparam logic [2:0] BYTE_ADDR_LO = 3'd3;
   localparam logic [2:0] BYTE_WORD_HI = 3'd4;
   localparam logic [2:0] BYTE_WORD_LO = 3'd5;
   localparam logic [2:0] BYTE_CRC_LO  = 3'd6;
   localparam logic [2:0] BYTE_CRC_HI  = 3'd7;

   typedef struct packed {
      logic [7:0]  slave_id;
      logic [7:0]  fcode;
      logic [15:0] reg_address;
      logic [15:0] word;
   } frame_head_type;

   // One byte of the reflected CRC-16, least significant bit first.
   function automatic logic [15:0] crc_byte_update(input logic [15:0] crc,
                                                   input logic [7:0] data);
      logic [15:0] acc;
      int i;
      acc = crc ^ {8'h00, data};
      for (i = 0; i < 8; i++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

endpackage

@@ src/rtu_frm_if.sv @@
interface rtu_frm_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [7:0]  slave_id;
   logic [15:0] reg_address;
   logic [15:0] operand_word;

   modport source (output valid, action, slave_id, reg_address, operand_word,
                   input ready);
   modport sink   (input valid, action, slave_id, reg_address, operand_word,
                   output ready);
endinterface

interface rtu_frm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_byte;

   modport source (output valid, frame_byte, last_byte, input ready);
   modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

@@ src/rtu_frm_stage.sv @@
module rtu_frm_stage (
   input  logic                        clock,
   input  logic                        reset,
   rtu_frm_req_if.sink                 req_chan,
   output logic                        head_valid,
   output rtu_frm_pkg::frame_head_type head,
   input  logic                        head_take
);
   import rtu_frm_pkg::*;

   logic           valid_ff, valid_in;
   frame_head_type head_ff, head_in;
   logic           accept;

   assign req_chan.ready = !valid_ff || head_take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      head_in  = head_ff;
      if (head_take) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in            = 1'b1;
         head_in.slave_id    = req_chan.slave_id;
         head_in.reg_address = req_chan.reg_address;
         if (req_chan.action == ACTION_WRITE) begin
            head_in.fcode = FC_WRITE;
            head_in.word  = req_chan.operand_word;
         end else begin
            // A read asks for at most 125 registers.
            head_in.fcode = FC_READ;
            head_in.word  = (req_chan.operand_word > MAX_READ_QTY) ?
                            MAX_READ_QTY : req_chan.operand_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      head_ff <= head_in;
   end

   assign head_valid = valid_ff;
   assign head       = head_ff;

endmodule

@@ src/rtu_frm_serializer.sv @@
module rtu_frm_serializer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        head_valid,
   input  rtu_frm_pkg::frame_head_type head,
   output logic                        head_take,
   rtu_frm_rsp_if.source               rsp_chan
);
   import rtu_frm_pkg::*;

   logic           active_ff, active_in;
   logic [2:0]     idx_ff, idx_in;
   frame_head_type frame_ff, frame_in;
   logic [15:0]    crc_ff, crc_in;
   logic           out_valid_ff, out_valid_in;
   logic [7:0]     out_byte_ff, out_byte_in;
   logic           out_last_ff, out_last_in;

   logic           advance;
   logic           emit;
   logic           finishing;
   logic [7:0]     cur_byte;

   assign advance   = !out_valid_ff || rsp_chan.ready;
   assign emit      = active_ff && advance;
   assign finishing = emit && (idx_ff == BYTE_CRC_HI);
   // The next frame is loaded in the same cycle the last byte is loaded into the output register.
   assign head_take = head_valid && (!active_ff || finishing);

   always_comb begin
      case (idx_ff)
         BYTE_SLAVE:   cur_byte = frame_ff.slave_id;
         BYTE_FCODE:   cur_byte = frame_ff.fcode;
         BYTE_ADDR_HI: cur_byte = frame_ff.reg_address[15:8];
         BYTE_ADDR_LO: cur_byte = frame_ff.reg_address[7:0];
         BYTE_WORD_HI: cur_byte = frame_ff.word[15:8];
         BYTE_WORD_LO: cur_byte = frame_ff.word[7:0];
         BYTE_CRC_LO:  cur_byte = crc_ff[7:0];
         BYTE_CRC_HI:  cur_byte = crc_ff[15:8];
         default:      cur_byte = 8'h00;
      endcase
   end

   always_comb begin
      active_in    = active_ff;
      idx_in       = idx_ff;
      frame_in     = frame_ff;
      crc_in       = crc_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;

      if (advance) begin
         out_valid_in = emit;
         out_byte_in  = cur_byte;
         out_last_in  = (idx_ff == BYTE_CRC_HI);
      end

      if (emit) begin
         idx_in = idx_ff + 3'd1;
         // The checksum covers the six header bytes only.
         if (idx_ff < BYTE_CRC_LO) begin
            crc_in = crc_byte_update(crc_ff, cur_byte);
         end
         if (finishing) begin
            active_in = 1'b0;
         end
      end

      if (head_take) begin
         active_in = 1'b1;
         idx_in    = BYTE_SLAVE;
         frame_in  = head;
         crc_in    = CRC_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= BYTE_SLAVE;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      frame_ff    <= frame_in;
      crc_ff      <= crc_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.frame_byte = out_byte_ff;
   assign rsp_chan.last_byte  = out_last_ff;

endmodule

@@ src/rtu_request_framer_crc16_top.sv @@
// A request is registered in the stage, then loaded into the serializer's frame register,
// and each frame byte passes through the output register before it is valid. Frame bytes
// go out one per cycle unless the output stalls; the serializer updates the CRC a byte at a time.
// A second request is held in the input register while the current frame goes out.
// Reset is synchronous and active high; it clears all valid and sequencing state.
module rtu_request_framer_crc16_top (
   input  logic          clock,
   input  logic          reset,
   rtu_frm_req_if.sink   req_chan,
   rtu_frm_rsp_if.source rsp_chan
);
   import rtu_frm_pkg::*;

   logic           head_valid;
   frame_head_type head;
   logic           head_take;

   rtu_frm_stage u_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .head_valid (head_valid),
      .head       (head),
      .head_take  (head_take)
   );

   rtu_frm_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .head_take  (head_take),
      .rsp_chan   (rsp_chan)
   );

endmodule

@@ sim/rtu_request_framer_crc16_top_tb.sv @@
`timescale 1ns / 1ps

module rtu_request_framer_crc16_top_tb;
   import rtu_frm_pkg::*;

   localparam int RANDOM_ITEMS = 500;
   localparam int CHUNK_ITEMS  = 100;
   localparam int TAIL_CYCLES  = 16;
   localparam int MAX_PRINTS   = 40;
   // The slowest legal run is about 520 requests, each with 8 bytes that may
   // each wait out the longest output stall; this limit leaves several times that.
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int N_DIRECTED   = 18;

   typedef struct packed {
      logic        typed;
      logic        action;
      logic [7:0]  slave_id;
      logic [15:0] reg_address;
      logic [15:0] operand_word;
      logic [7:0]  exp_fcode;
      logic [15:0] exp_word;
   } request_row_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } frame_byte_type;

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   error_count = 0;
   int   stall_left = 0;
   bit   tx_idle_on;
   bit   rx_idle_on;

   frame_byte_type pending_bytes[$];

   rtu_frm_req_if req_if();
   rtu_frm_rsp_if rsp_if();

   rtu_request_framer_crc16_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Rows with typed set carry the function code and the word as they must
   // appear on the line; the CRC bytes always come from the predictor.
   request_row_type directed_rows [N_DIRECTED] = '{
      '{1'b1, ACTION_READ,  8'h01, 16'h0000, 16'h000A, FC_READ,  16'h000A},
      '{1'b1, ACTION_READ,  8'h00, 16'h0000, 16'h0000, FC_READ,  16'h0000},
      '{1'b1, ACTION_READ,  8'hFF, 16'hFFFF, 16'h007D, FC_READ,  16'h007D},
      '{1'b1, ACTION_READ,  8'h11, 16'h006B, 16'h007E, FC_READ,  16'h007D},
      '{1'b1, ACTION_READ,  8'h11, 16'h006B, 16'hFFFF, FC_READ,  16'h007D},
      '{1'b1, ACTION_READ,  8'hA5, 16'h8000, 16'h8000, FC_READ,  16'h007D},
      '{1'b1, ACTION_READ,  8'h5A, 16'h0001, 16'h0001, FC_READ,  16'h0001},
      '{1'b1, ACTION_READ,  8'h80, 16'h7FFF, 16'h007C, FC_READ,  16'h007C},
      '{1'b1, ACTION_READ,  8'h01, 16'h0100, 16'h0100, FC_READ,  16'h007D},
      '{1'b1, ACTION_WRITE, 8'h01, 16'h0000, 16'h0000, FC_WRITE, 16'h0000},
      '{1'b1, ACTION_WRITE, 8'hFF, 16'hFFFF, 16'hFFFF, FC_WRITE, 16'hFFFF},
      '{1'b1, ACTION_WRITE, 8'h11, 16'h0001, 16'h007E, FC_WRITE, 16'h007E},
      '{1'b1, ACTION_WRITE, 8'h55, 16'hAAAA, 16'h5555, FC_WRITE, 16'h5555},
      '{1'b1, ACTION_WRITE, 8'hAA, 16'h5555, 16'hAAAA, FC_WRITE, 16'hAAAA},
      '{1'b0, ACTION_READ,  8'h7F, 16'h1234, 16'h0040, 8'h00,    16'h0000},
      '{1'b0, ACTION_WRITE, 8'h0F, 16'hFEDC, 16'h0003, 8'h00,    16'h0000},
      '{1'b0, ACTION_READ,  8'hF0, 16'h00FF, 16'h007F, 8'h00,    16'h0000},
      '{1'b0, ACTION_WRITE, 8'h00, 16'h0000, 16'h8001, 8'h00,    16'h0000}
   };

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      if (error_count < MAX_PRINTS) begin
         $display("cycle %0d: %s", cycle_count, what);
      end
      error_count++;
   endtask

   // Reflected CRC-16 over the six header bytes, first byte at the top.
   function automatic logic [15:0] crc16_over_head(input logic [47:0] head);
      logic [15:0] acc;
      int i;
      int b;
      acc = CRC_INIT;
      for (i = 0; i < 6; i++) begin
         acc = acc ^ {8'h00, head[47 - 8 * i -: 8]};
         for (b = 0; b < 8; b++) begin
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
         end
      end
      return acc;
   endfunction

   task automatic expect_frame(input request_row_type r);
      logic [7:0]     fcode;
      logic [15:0]    word;
      logic [47:0]    head;
      logic [15:0]    crc;
      logic [7:0]     b;
      frame_byte_type fb;
      int k;
      if (r.typed) begin
         fcode = r.exp_fcode;
         word = r.exp_word;
      end else if (r.action == ACTION_WRITE) begin
         fcode = FC_WRITE;
         word = r.operand_word;
      end else begin
         fcode = FC_READ;
         word = (r.operand_word > MAX_READ_QTY) ? MAX_READ_QTY : r.operand_word;
      end
      head = {r.slave_id, fcode, r.reg_address, word};
      crc = crc16_over_head(head);
      for (k = 0; k < 8; k++) begin
         if (k < 6) begin
            b = head[47 - 8 * k -: 8];
         end else if (k == 6) begin
            b = crc[7:0];
         end else begin
            b = crc[15:8];
         end
         fb.frame_byte = b;
         fb.last_byte = (k == 7);
         pending_bytes = {pending_bytes, fb};
      end
   endtask

   function automatic request_row_type random_request();
      request_row_type r;
      r = '0;
      r.action = 1'($urandom_range(0, 1));
      r.slave_id = 8'($urandom);
      r.reg_address = 16'($urandom);
      case ($urandom_range(0, 3))
         0: begin
            r.operand_word = 16'($urandom_range(0, 130));
         end
         1: begin
            r.operand_word = 16'($urandom_range(120, 130));
         end
         default: begin
            r.operand_word = 16'($urandom);
         end
      endcase
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!tx_idle_on || roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 30);
   endfunction

   // Entered and left at a falling edge; the request is queued for checking
   // at the rising edge that accepts it.
   task automatic send_request(input request_row_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.action = r.action;
      req_if.slave_id = r.slave_id;
      req_if.reg_address = r.reg_address;
      req_if.operand_word = r.operand_word;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      expect_frame(r);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_if.valid = 1'b0;
      while (pending_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready = 1'b0;
      end else if (stall_left > 0) begin
         rsp_if.ready = 1'b0;
         stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 99) < 12) begin
         rsp_if.ready = 1'b0;
         if ($urandom_range(0, 19) == 0) begin
            stall_left = $urandom_range(10, 40) - 1;
         end else begin
            stall_left = $urandom_range(1, 3) - 1;
         end
      end else begin
         rsp_if.ready = 1'b1;
      end
   end

   always @(posedge clock) begin : check_bytes
      frame_byte_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected frame byte %02h", rsp_if.frame_byte));
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_if.frame_byte !== want.frame_byte) begin
               report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                         rsp_if.frame_byte, want.frame_byte));
            end
            if (rsp_if.last_byte !== want.last_byte) begin
               report_mismatch($sformatf("last_byte %b, expected %b",
                                         rsp_if.last_byte, want.last_byte));
            end
         end
      end
   end

   initial begin
      int c;
      int n;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.action = ACTION_READ;
      req_if.slave_id = '0;
      req_if.reg_address = '0;
      req_if.operand_word = '0;
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i]);
      end
      wait_for_drain();

      // Chunk 1 sends back to back, chunk 2 never stalls the output side,
      // chunk 3 runs with no idling at all.
      for (c = 0; c < RANDOM_ITEMS / CHUNK_ITEMS; c++) begin
         tx_idle_on = !(c == 1 || c == 3);
         rx_idle_on = !(c == 2 || c == 3);
         for (n = 0; n < CHUNK_ITEMS; n++) begin
            send_request(random_request());
         end
         if (c == 2) begin
            wait_for_drain();
         end
      end
      wait_for_drain();

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/rtu_frm_pkg.sv
src/rtu_frm_if.sv
src/rtu_frm_stage.sv
src/rtu_frm_serializer.sv
src/rtu_request_framer_crc16_top.sv
sim/rtu_request_framer_crc16_top_tb.sv
